// ===== rtl/aas_pkg.sv =====
// aas_pkg: shared types and constants for the amplitude artifact segmenter
// no dependencies; used by aas_cfg_regs, aas_seg_core and the top level
package aas_pkg;

    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int LEVEL_W     = 24;
    localparam int CHAN_CNT_W  = 10;
    localparam int RUN_LEN_W   = 24;
    localparam int SEG_FIELD_W = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_PEAK_LEVEL       = 2'd0;
    localparam logic [1:0] REG_FLAT_LEVEL       = 2'd1;
    localparam logic [1:0] REG_MIN_BAD_CHANNELS = 2'd2;
    localparam logic [1:0] REG_MIN_RUN_LENGTH   = 2'd3;

    localparam logic [LEVEL_W-1:0]    PEAK_LEVEL_RST       = 24'd8388608;
    localparam logic [LEVEL_W-1:0]    FLAT_LEVEL_RST       = 24'd0;
    localparam logic [CHAN_CNT_W-1:0] MIN_BAD_CHANNELS_RST = 10'd1;
    localparam logic [RUN_LEN_W-1:0]  MIN_RUN_LENGTH_RST   = 24'd0;

    // bad channel counter saturates here
    localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_MAX = 10'd1023;

    typedef struct packed {
        logic [LEVEL_W-1:0]    peak_level;
        logic [LEVEL_W-1:0]    flat_level;
        logic [CHAN_CNT_W-1:0] min_bad_channels;
        logic [RUN_LEN_W-1:0]  min_run_length;
    } cfg_t;

    typedef struct packed {
        logic                   emit;
        logic [SEG_FIELD_W-1:0] segment_start;
        logic [SEG_FIELD_W-1:0] segment_length;
    } seg_result_t;

endpackage

// ===== rtl/aas_cfg_regs.sv =====
// aas_cfg_regs: apb-style configuration register file
// depends on aas_pkg for the register layout and reset values
module aas_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [aas_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [aas_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [aas_pkg::CFG_DATA_W-1:0]  prdata,
    output aas_pkg::cfg_t                   cfg
);

    aas_pkg::cfg_t cfg_reg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_level       <= aas_pkg::PEAK_LEVEL_RST;
            cfg_reg.flat_level       <= aas_pkg::FLAT_LEVEL_RST;
            cfg_reg.min_bad_channels <= aas_pkg::MIN_BAD_CHANNELS_RST;
            cfg_reg.min_run_length   <= aas_pkg::MIN_RUN_LENGTH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                aas_pkg::REG_PEAK_LEVEL:
                    cfg_reg.peak_level <= pwdata[aas_pkg::LEVEL_W-1:0];
                aas_pkg::REG_FLAT_LEVEL:
                    cfg_reg.flat_level <= pwdata[aas_pkg::LEVEL_W-1:0];
                aas_pkg::REG_MIN_BAD_CHANNELS:
                    cfg_reg.min_bad_channels <= pwdata[aas_pkg::CHAN_CNT_W-1:0];
                aas_pkg::REG_MIN_RUN_LENGTH:
                    cfg_reg.min_run_length <= pwdata[aas_pkg::RUN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            aas_pkg::REG_PEAK_LEVEL:
                prdata = aas_pkg::CFG_DATA_W'(cfg_reg.peak_level);
            aas_pkg::REG_FLAT_LEVEL:
                prdata = aas_pkg::CFG_DATA_W'(cfg_reg.flat_level);
            aas_pkg::REG_MIN_BAD_CHANNELS:
                prdata = aas_pkg::CFG_DATA_W'(cfg_reg.min_bad_channels);
            aas_pkg::REG_MIN_RUN_LENGTH:
                prdata = aas_pkg::CFG_DATA_W'(cfg_reg.min_run_length);
            default: prdata = '0;
        endcase
    end

endmodule

// ===== rtl/aas_seg_core.sv =====
// aas_seg_core: per-sample classification, time point decision and segment tracking
// depends on aas_pkg for cfg_t, seg_result_t and the counter limit
module aas_seg_core
#(
    parameter int SAMPLE_BITS = 24,
    parameter int TIME_BITS   = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  aas_pkg::cfg_t          cfg,
    input  logic                   advance,
    input  logic [SAMPLE_BITS-1:0] sample_value,
    input  logic                   last_channel,
    input  logic                   end_of_record,
    output aas_pkg::seg_result_t   result
);

    localparam int MAG_W = (SAMPLE_BITS > aas_pkg::LEVEL_W) ? SAMPLE_BITS : aas_pkg::LEVEL_W;
    localparam int CMP_W = (TIME_BITS > aas_pkg::RUN_LEN_W) ? TIME_BITS : aas_pkg::RUN_LEN_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [aas_pkg::CHAN_CNT_W-1:0] bad_cnt_reg, bad_cnt_next;
    logic [TIME_BITS-1:0]           time_index_reg, time_index_next;
    logic                           in_segment_reg, in_segment_next;
    logic [TIME_BITS-1:0]           seg_begin_reg, seg_begin_next;

    logic [SAMPLE_BITS-1:0]         mag;
    logic [MAG_W-1:0]               mag_ext;
    logic                           sample_bad;
    logic [aas_pkg::CHAN_CNT_W-1:0] cnt_upd;
    logic                           tp_bad;
    logic [TIME_BITS-1:0]           time_inc;
    logic [TIME_BITS-1:0]           begin_upd;
    logic [TIME_BITS-1:0]           len_end;
    logic                           close_run;
    logic                           close_eor;
    logic [TIME_BITS-1:0]           run_len;
    logic                           long_enough;

    // two's complement negate gives 2^(n-1) for the most negative code, as wanted
    assign mag        = sample_value[SAMPLE_BITS-1] ? (~sample_value + 1'b1) : sample_value;
    assign mag_ext    = MAG_W'(mag);
    assign sample_bad = (mag_ext > MAG_W'(cfg.peak_level)) || (mag_ext < MAG_W'(cfg.flat_level));
    assign cnt_upd    = (sample_bad && (bad_cnt_reg != aas_pkg::CHAN_CNT_MAX))
                      ? bad_cnt_reg + 1'b1 : bad_cnt_reg;
    assign tp_bad     = cnt_upd >= cfg.min_bad_channels;
    assign time_inc   = (time_index_reg == TIME_MAX) ? time_index_reg : time_index_reg + 1'b1;
    assign begin_upd  = (tp_bad && !in_segment_reg) ? time_index_reg : seg_begin_reg;

    // a run ends on a good time point, or is cut at the end of the record
    assign close_run   = last_channel && !tp_bad && in_segment_reg;
    assign close_eor   = last_channel && end_of_record && tp_bad;
    assign len_end     = close_eor ? time_inc : time_index_reg;
    assign run_len     = len_end - begin_upd;
    assign long_enough = CMP_W'(run_len) >= CMP_W'(cfg.min_run_length);

    assign result.emit           = (close_run || close_eor) && long_enough;
    assign result.segment_start  = aas_pkg::SEG_FIELD_W'(begin_upd);
    assign result.segment_length = aas_pkg::SEG_FIELD_W'(run_len);

    always_comb
    begin
        bad_cnt_next    = cnt_upd;
        time_index_next = time_index_reg;
        in_segment_next = in_segment_reg;
        seg_begin_next  = seg_begin_reg;
        if (last_channel)
        begin
            bad_cnt_next = '0;
            if (end_of_record)
            begin
                time_index_next = '0;
                in_segment_next = 1'b0;
                seg_begin_next  = '0;
            end
            else
            begin
                time_index_next = time_inc;
                in_segment_next = tp_bad;
                seg_begin_next  = begin_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_cnt_reg    <= '0;
            time_index_reg <= '0;
            in_segment_reg <= 1'b0;
            seg_begin_reg  <= '0;
        end
        else if (advance)
        begin
            bad_cnt_reg    <= bad_cnt_next;
            time_index_reg <= time_index_next;
            in_segment_reg <= in_segment_next;
            seg_begin_reg  <= seg_begin_next;
        end
    end

    // record end clears the whole tracking state
    a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_channel && end_of_record) |=>
            (time_index_reg == '0) && !in_segment_reg && (bad_cnt_reg == '0))
        else $error("tracking state not cleared after record end");

    // time index moves only on the last channel of a time point
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last_channel) |=> $stable(time_index_reg))
        else $error("time index moved inside a time point");

    // an open run never begins after the current time index
    a_begin_order: assert property (@(posedge clk) disable iff (!rst_n)
        in_segment_reg |-> (seg_begin_reg <= time_index_reg))
        else $error("open run begins after current time index");

endmodule

// ===== rtl/amplitude_artifact_segmenter.sv =====
// amplitude_artifact_segmenter: top level with input register, result register and apb port
// depends on aas_pkg, aas_cfg_regs and aas_seg_core
//
// Peak/flat amplitude artifact segmenter. Channel samples stream in on s_axis one per
// request, in time-point order; s_axis_tlast marks the last channel of a time point and
// s_axis_tuser, together with tlast, marks the final time point of a record. A sample is
// bad when its magnitude is above peak_level or below flat_level; a time point is bad when
// its bad channel count reaches min_bad_channels. Each run of bad time points that is at
// least min_run_length long comes out on m_axis as one request (start index, length); a run
// still open at the record end is closed there and all counters return to zero. The block
// takes one sample per clock unless stalled: a sample is latched into an input register,
// then classified and folded into the segment state when it advances, and a finished
// segment is held in an output register, from which it is offered on m_axis. Input is
// stalled only while a sample is waiting and the output register holds a segment not yet
// taken.
// Configuration registers (byte addresses): 0x0 peak_level, 0x4 flat_level,
// 0x8 min_bad_channels, 0xC min_run_length; write them only while the stream is idle.
module amplitude_artifact_segmenter
#(
    parameter int SAMPLE_BITS = 24,
    parameter int TIME_BITS   = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    // sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample_value, zero pad
    input  logic                                s_axis_tlast,   // last_channel
    input  logic                                s_axis_tuser,   // end_of_record

    // segment stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*aas_pkg::SEG_FIELD_W-1:0]   m_axis_tdata,   // length high, start low

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aas_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [aas_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [aas_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    aas_pkg::cfg_t         cfg;
    aas_pkg::seg_result_t  result;

    // input register
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_last_reg;
    logic                   in_eor_reg;

    // result register
    logic                   out_valid_reg;
    logic [2*aas_pkg::SEG_FIELD_W-1:0] out_data_reg;

    logic advance;
    logic in_take;

    // the held sample moves on once the result register can take whatever it produces
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign pready        = 1'b1;

    aas_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    aas_seg_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_seg_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .advance       (advance),
        .sample_value  (in_sample_reg),
        .last_channel  (in_last_reg),
        .end_of_record (in_eor_reg),
        .result        (result)
    );

    // input valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_axis_tlast;
            in_eor_reg    <= s_axis_tuser;
        end
    end

    // result valid flag: loaded on every advance, dropped once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_data_reg <= {result.segment_length, result.segment_start};
        end
    end

    // input stalls only behind a held sample and an untaken segment
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // a fresh segment only follows a sample that closed a time point
    a_emit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.emit) |-> in_last_reg)
        else $error("segment emitted inside a time point");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for amplitude_artifact_segmenter
// drives samples and apb writes, predicts segments in a scoreboard class
// depends on aas_pkg and the rtl of amplitude_artifact_segmenter
`timescale 1ns / 100ps

module tb;

    localparam int SAMPLE_W        = 24;
    localparam int TIME_W          = 32;
    localparam int RANDOM_ITEMS    = 500;
    localparam int SETTLE_CYCLES   = 4;     // slack after the last segment
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int BURST_ITEMS     = 40;
    localparam int SATURATE_ITEMS  = 1100;  // more bad channels than the counter can hold
    localparam int MAG_MAX         = 8388608;

    typedef struct {
        logic [aas_pkg::SEG_FIELD_W-1:0] start;
        logic [aas_pkg::SEG_FIELD_W-1:0] length;
    } segment_t;

    // predicts segments from accepted samples and checks the segment stream
    class segment_tracker;
        aas_pkg::cfg_t                  settings;
        logic [aas_pkg::CHAN_CNT_W-1:0] bad_channels;
        logic [TIME_W-1:0]              point_index;
        bit                             run_open;
        logic [TIME_W-1:0]              run_first;
        segment_t                       awaited_segments[$];
        int                             error_count;

        function new();
            settings.peak_level       = aas_pkg::PEAK_LEVEL_RST;
            settings.flat_level       = aas_pkg::FLAT_LEVEL_RST;
            settings.min_bad_channels = aas_pkg::MIN_BAD_CHANNELS_RST;
            settings.min_run_length   = aas_pkg::MIN_RUN_LENGTH_RST;
            bad_channels = '0;
            point_index  = '0;
            run_open     = 1'b0;
            run_first    = '0;
            error_count  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [aas_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                aas_pkg::REG_PEAK_LEVEL:
                    settings.peak_level       = value[aas_pkg::LEVEL_W-1:0];
                aas_pkg::REG_FLAT_LEVEL:
                    settings.flat_level       = value[aas_pkg::LEVEL_W-1:0];
                aas_pkg::REG_MIN_BAD_CHANNELS:
                    settings.min_bad_channels = value[aas_pkg::CHAN_CNT_W-1:0];
                aas_pkg::REG_MIN_RUN_LENGTH:
                    settings.min_run_length   = value[aas_pkg::RUN_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void close_run(logic [TIME_W-1:0] stop);
            logic [TIME_W-1:0] len;
            segment_t          found;
            len = stop - run_first;
            if (len >= TIME_W'(settings.min_run_length)) begin
                found.start      = run_first;
                found.length     = len;
                awaited_segments = {awaited_segments, found};
            end
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw, bit last, bit eor);
            logic [SAMPLE_W:0] mag;
            bit                point_bad;
            logic [TIME_W-1:0] next_index;
            // most negative sample has magnitude 2^23 exactly
            mag = raw[SAMPLE_W-1] ? ((25'd1 << SAMPLE_W) - {1'b0, raw}) : {1'b0, raw};
            if ((mag > {1'b0, settings.peak_level} || mag < {1'b0, settings.flat_level})
                && bad_channels < aas_pkg::CHAN_CNT_MAX)
                bad_channels = bad_channels + 1'b1;
            if (!last)
                return;
            point_bad    = bad_channels >= settings.min_bad_channels;
            bad_channels = '0;
            if (point_bad && !run_open) begin
                run_open  = 1'b1;
                run_first = point_index;
            end
            else if (!point_bad && run_open) begin
                run_open = 1'b0;
                close_run(point_index);
            end
            next_index = (point_index == '1) ? point_index : point_index + 1'b1;
            if (eor) begin
                if (run_open)
                    close_run(next_index);
                run_open    = 1'b0;
                point_index = '0;
                run_first   = '0;
            end
            else begin
                point_index = next_index;
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            error_count++;
        endtask

        task check_segment(logic [2*aas_pkg::SEG_FIELD_W-1:0] beat);
            segment_t want;
            if (awaited_segments.size() == 0) begin
                report_mismatch($sformatf("segment start %0d length %0d with none pending",
                                          beat[aas_pkg::SEG_FIELD_W-1:0],
                                          beat[2*aas_pkg::SEG_FIELD_W-1:aas_pkg::SEG_FIELD_W]));
                return;
            end
            want = awaited_segments.pop_front();
            if (beat[aas_pkg::SEG_FIELD_W-1:0] !== want.start)
                report_mismatch($sformatf("segment_start %0d, predicted %0d",
                                          beat[aas_pkg::SEG_FIELD_W-1:0], want.start));
            if (beat[2*aas_pkg::SEG_FIELD_W-1:aas_pkg::SEG_FIELD_W] !== want.length)
                report_mismatch($sformatf("segment_length %0d, predicted %0d",
                                          beat[2*aas_pkg::SEG_FIELD_W-1:aas_pkg::SEG_FIELD_W],
                                          want.length));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [SAMPLE_W-1:0]               s_axis_tdata  = '0;    // sample_value
    logic                              s_axis_tlast  = 1'b0;  // last_channel
    logic                              s_axis_tuser  = 1'b0;  // end_of_record

    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [2*aas_pkg::SEG_FIELD_W-1:0] m_axis_tdata;          // segment_length (upper half), segment_start (lower half)

    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [aas_pkg::CFG_ADDR_W-1:0]    paddr   = '0;
    logic [aas_pkg::CFG_DATA_W-1:0]    pwdata  = '0;
    logic [aas_pkg::CFG_DATA_W-1:0]    prdata;
    logic                              pready;

    segment_tracker tracker = new();

    bit sender_quiet        = 1'b0;  // no gaps between sample requests
    bit output_hold_request = 1'b0;  // asks the sink for one long hold-off
    int random_items        = 0;

    amplitude_artifact_segmenter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // fixed time limit, far above the slowest legal run
    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // both streams are sampled at the rising edge, segments checked before new samples
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_segment(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_sample(s_axis_tdata, s_axis_tlast, s_axis_tuser);
        end
    end

    // segment sink: random stalls per request, stretches without stalls,
    // and one long hold-off counted here while the source keeps offering samples
    initial
    begin : segment_sink
        int unsigned gap;
        int unsigned held;
        bit          quiet;
        quiet = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (output_hold_request) begin
                output_hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(negedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // one sample request, returns at the edge where it is taken
    task automatic send_sample(logic [SAMPLE_W-1:0] value, bit last, bit eor);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        s_axis_tuser  <= eor;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop the source and let every pending segment come out
    task automatic wait_for_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_register(logic [1:0] idx, logic [aas_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(int peak, int flat, int min_bad, int run_len);
        write_register(aas_pkg::REG_PEAK_LEVEL,       aas_pkg::CFG_DATA_W'(peak));
        write_register(aas_pkg::REG_FLAT_LEVEL,       aas_pkg::CFG_DATA_W'(flat));
        write_register(aas_pkg::REG_MIN_BAD_CHANNELS, aas_pkg::CFG_DATA_W'(min_bad));
        write_register(aas_pkg::REG_MIN_RUN_LENGTH,   aas_pkg::CFG_DATA_W'(run_len));
    endtask

    // sample near the thresholds, leaning bad or good, sometimes fully random
    function automatic logic [SAMPLE_W-1:0] pick_sample(bit want_bad);
        int          peak;
        int          flat;
        int          mag;
        int unsigned sel;
        peak = int'(tracker.settings.peak_level);
        flat = int'(tracker.settings.flat_level);
        sel  = $urandom_range(0, 11);
        if (sel == 0)
            return SAMPLE_W'($urandom);
        if (want_bad) begin
            case (sel % 4)
                0:       mag = peak + 1;
                1:       mag = peak + int'($urandom_range(1, 4096));
                2:       mag = flat - 1;
                default: mag = flat - int'($urandom_range(1, 4096));
            endcase
        end
        else begin
            case (sel % 3)
                0:       mag = peak;
                1:       mag = flat;
                default: mag = int'($urandom_range(flat, peak));
            endcase
        end
        if (mag < 0)
            mag = 0;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        if (mag == MAG_MAX || (mag != 0 && $urandom_range(0, 1) == 1))
            return SAMPLE_W'(-mag);
        return SAMPLE_W'(mag);
    endfunction

    // register settings per phase, the first ones at the extremes
    task automatic configure_phase(int phase);
        int peak;
        int flat;
        int min_bad;
        int run_len;
        case (phase)
            0: begin
                peak = 0;        flat = 0;        min_bad = 1; run_len = 0;
            end
            1: begin
                peak = MAG_MAX;  flat = MAG_MAX;  min_bad = 2; run_len = 1;
            end
            2: begin
                peak = int'($urandom_range(0, MAG_MAX));
                flat = int'($urandom_range(0, peak));
                min_bad = 0;
                run_len = 24'hFFFFFF;  // runs never long enough
            end
            default: begin
                peak = ($urandom_range(0, 7) == 0) ? MAG_MAX : int'($urandom_range(0, MAG_MAX));
                if ($urandom_range(0, 7) == 0)
                    flat = 0;
                else if ($urandom_range(0, 9) == 0)
                    flat = int'($urandom_range(0, MAG_MAX));
                else
                    flat = int'($urandom_range(0, peak));
                min_bad = int'($urandom_range(0, 4));
                run_len = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
            end
        endcase
        write_all(peak, flat, min_bad, run_len);
    endtask

    // mostly well-formed records with random content, some with random framing
    task automatic send_random_record();
        int unsigned channels;
        int unsigned points;
        int unsigned bad_rate;
        int unsigned point_rate;
        bit          broken;
        bit          last;
        bit          eor;
        channels = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        points   = $urandom_range(1, 30);
        bad_rate = $urandom_range(0, 100);
        broken   = $urandom_range(0, 9) == 0;
        sender_quiet = $urandom_range(0, 3) == 0;
        for (int tp = 0; tp < points; tp++) begin
            point_rate = ($urandom_range(0, 99) < bad_rate) ? 85 : 5;
            for (int ch = 0; ch < channels; ch++) begin
                last = ch == channels - 1;
                eor  = last && tp == points - 1;
                if (broken) begin
                    last = $urandom_range(0, 3) == 0;
                    eor  = $urandom_range(0, 5) == 0;
                end
                else if (!last && $urandom_range(0, 19) == 0) begin
                    eor = 1'b1;  // end flag without last channel is ignored
                end
                send_sample(pick_sample($urandom_range(0, 99) < point_rate), last, eor);
                random_items++;
            end
        end
        // close a badly framed record so the next phase starts clean
        if (broken) begin
            send_sample(pick_sample(1'b0), 1'b1, 1'b1);
            random_items++;
        end
    endtask

    initial
    begin : sample_source
        int phase;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset levels: even the most negative sample is not above the peak level
        send_sample(24'h800000, 1'b1, 1'b1);
        send_sample(24'h7FFFFF, 1'b1, 1'b1);

        // boundaries at both levels, one segment closed by a good point,
        // one closed at the record end
        wait_for_idle();
        write_all(1000, 10, 1, 0);
        send_sample(SAMPLE_W'(5),     1'b1, 1'b0);
        send_sample(SAMPLE_W'(1001),  1'b1, 1'b0);
        send_sample(SAMPLE_W'(-9),    1'b1, 1'b0);
        send_sample(SAMPLE_W'(1000),  1'b1, 1'b0);
        send_sample(SAMPLE_W'(-1000), 1'b0, 1'b1);
        send_sample(SAMPLE_W'(10),    1'b1, 1'b0);
        send_sample(24'h800000,       1'b1, 1'b0);
        send_sample(24'h7FFFFF,       1'b1, 1'b1);

        // zero minimum channels: every point bad, run of three just long enough
        wait_for_idle();
        write_register(aas_pkg::REG_MIN_BAD_CHANNELS, 32'd0);
        write_register(aas_pkg::REG_MIN_RUN_LENGTH,   32'd3);
        send_sample(SAMPLE_W'(0), 1'b1, 1'b0);
        send_sample(SAMPLE_W'(0), 1'b1, 1'b0);
        send_sample(SAMPLE_W'(0), 1'b1, 1'b1);

        // longest minimum length: nothing reported
        wait_for_idle();
        write_register(aas_pkg::REG_MIN_RUN_LENGTH, 32'hFFFFFF);
        send_sample(SAMPLE_W'(5), 1'b1, 1'b1);

        // minimum channels of 512 with extreme levels
        wait_for_idle();
        write_all(0, MAG_MAX, 512, 0);
        send_sample(SAMPLE_W'(0), 1'b1, 1'b1);

        // one segment per sample while the sink holds off, so the block backs up
        wait_for_idle();
        write_all(0, 0, 0, 0);
        sender_quiet        = 1'b1;
        output_hold_request = 1'b1;
        repeat (BURST_ITEMS)
            send_sample(SAMPLE_W'($urandom), 1'b1, 1'b1);

        // bad channel counter must saturate rather than wrap past 1023
        wait_for_idle();
        write_register(aas_pkg::REG_MIN_BAD_CHANNELS, 32'd512);
        for (int ch = 0; ch < SATURATE_ITEMS; ch++)
            send_sample(SAMPLE_W'($urandom) | 24'h1, ch == SATURATE_ITEMS - 1,
                        ch == SATURATE_ITEMS - 1);

        // random phases, each with its own register settings
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_for_idle();
            configure_phase(phase);
            repeat ($urandom_range(1, 6))
                if (random_items < RANDOM_ITEMS)
                    send_random_record();
            phase++;
        end

        wait_for_idle();
        repeat (10) @(posedge clk);
        if (tracker.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
